// ----- hdl/kfs_pkg.sv -----
// Shared types and constants for the key/fader scan to MIDI event block.
// No dependencies; imported by every module of the block.
package kfs_pkg;

  // Widths fixed by the transaction layout
  localparam int unsigned COL_W    = 4;
  localparam int unsigned LEVEL_W  = 6;
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned FADER_W  = 8;
  localparam int unsigned NOTE_W   = 7;
  localparam int unsigned VEL_W    = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  // USB MIDI code index and MIDI status bytes
  localparam logic [7:0] CIN_NOTE_ON     = 8'h09;
  localparam logic [7:0] CIN_NOTE_OFF    = 8'h08;
  localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
  localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FADER_DEADBAND  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FADER_NOTE_BASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_VELOCITY    = 2'd2;

  // Register reset values
  localparam logic [FADER_W-1:0] DEADBAND_RST  = 8'd2;
  localparam logic [NOTE_W-1:0]  NOTE_BASE_RST = 7'd100;
  localparam logic [VEL_W-1:0]   VELOCITY_RST  = 7'd127;

  // One pending note event
  typedef struct packed {
    logic              on;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  vel;
  } event_t;

endpackage

// ----- hdl/kfs_key_lane.sv -----
// One key row lane: detects a level change on its row and builds the event.
// Depends on kfs_pkg.
module kfs_key_lane import kfs_pkg::*; #(
  parameter int unsigned ROW     = 0,
  parameter int unsigned COLUMNS = 15
) (
  input  logic             now_i,
  input  logic             was_i,
  input  logic [COL_W-1:0] col_i,
  input  logic [VEL_W-1:0] velocity_i,
  output logic             hit_o,
  output event_t           ev_o
);

  localparam int unsigned NOTE_OFS = ROW * COLUMNS;

  assign hit_o    = now_i != was_i;
  assign ev_o.on  = ~now_i;  // active low: low level means pressed
  // note wraps modulo 128
  assign ev_o.note = NOTE_W'(NOTE_OFS) + NOTE_W'(col_i);
  assign ev_o.vel  = velocity_i;

endmodule

// ----- hdl/kfs_fader_lane.sv -----
// Fader lane: reduces the sample to 8 bits and applies the deadband.
// Depends on kfs_pkg.
module kfs_fader_lane import kfs_pkg::*; (
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic [FADER_W-1:0]  old_i,
  input  logic [FADER_W-1:0]  deadband_i,
  input  logic [NOTE_W-1:0]   base_i,
  input  logic [COL_W-1:0]    col_i,
  output logic                hit_o,
  output logic [FADER_W-1:0]  value_o,
  output event_t              ev_o
);

  logic [FADER_W-1:0] diff;

  assign value_o = sample_i[SAMPLE_W-1 -: FADER_W];
  assign diff    = (value_o > old_i) ? (value_o - old_i) : (old_i - value_o);
  assign hit_o   = diff > deadband_i;

  assign ev_o.on   = 1'b1;
  assign ev_o.note = base_i + NOTE_W'(col_i);
  assign ev_o.vel  = value_o[FADER_W-1:1];

endmodule

// ----- hdl/kfs_merge.sv -----
// Merge stage (needs kfs_pkg): holds the lane events of one scan and
// sends them out one per cycle unless stalled, lowest lane first.
module kfs_merge import kfs_pkg::*; #(
  parameter int unsigned LANES = 7
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic [LANES-1:0]  hit_i,
  input  event_t            ev_i [LANES],
  output logic              can_load_o,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [31:0]       m_axis_tdata,
  output logic              m_axis_tlast
);

  logic [LANES-1:0] mask_q, mask_d;
  event_t           ev_q [LANES];
  logic [LANES-1:0] pick, rest;
  event_t           sel;
  logic             out_free, pop;
  logic             out_valid_q, out_valid_d;
  logic             out_last_q;
  event_t           out_ev_q;

  assign pick     = mask_q & (~mask_q + LANES'(1));  // lowest set bit
  assign rest     = mask_q & ~pick;
  assign out_free = ~out_valid_q | m_axis_tready;
  assign pop      = (|mask_q) & out_free;
  assign can_load_o = ~(|mask_q) | (pop & ~(|rest));

  always_comb begin
    sel = '0;
    for (int i = 0; i < LANES; i++) begin
      sel = sel | (pick[i] ? ev_q[i] : '0);
    end
  end

  always_comb begin
    mask_d = mask_q;
    if (load_i) begin
      mask_d = hit_i;
    end else if (pop) begin
      mask_d = rest;
    end
    out_valid_d = out_valid_q;
    if (pop) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ev_q <= ev_i;
    end
    if (pop) begin
      out_ev_q   <= sel;
      out_last_q <= ~(|rest);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {2'b00, out_ev_q.vel, out_ev_q.note,
                          out_ev_q.on ? STATUS_NOTE_ON : STATUS_NOTE_OFF,
                          out_ev_q.on ? CIN_NOTE_ON : CIN_NOTE_OFF};

endmodule

// ----- hdl/key_fader_scan_to_midi_events_top.sv -----
// Top level of the key matrix / fader scanner to MIDI note event block.
// Depends on kfs_pkg, kfs_key_lane, kfs_fader_lane and kfs_merge.
//
// Each input transaction is one scanned column. ROWS key lanes and one fader
// lane compare it against the per-column state in the accept cycle and the
// state is updated right away, so a following scan of the same column sees
// it. The merge stage then sends the events one per cycle while the output is not
// stalled, in row order, the fader event last, with tlast on the final one; a scan that
// causes no event (or names a column at or above COLUMNS) produces nothing. Throughput
// is set by the single output register: a scan with several events holds the input
// while they pass through it in turn; the next scan is taken in the cycle the previous
// scan's last event moves to the output register, while older results still wait
// there. The first event passes through the merge stage's mask and event registers
// and then the output register. Stored key levels and fader values clear to zero at
// reset, so the first scan emits note off for every row reading high. Note numbers
// wrap modulo 128. Configuration writes must only happen while the block is idle;
// writes to an unused index are ignored.
module key_fader_scan_to_midi_events_top import kfs_pkg::*; #(
  parameter int unsigned COLUMNS = 15,
  parameter int unsigned ROWS    = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // config write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // scan input
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [23:0]           s_axis_tdata,  // column_index[3:0], row_levels[9:4],
                                               // fader_sample[21:10], zero pad
  // event output
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [31:0]           m_axis_tdata,  // code_index_byte[7:0], status_byte[15:8],
                                               // note_number[22:16],
                                               // velocity_value[29:23], zero pad
  output logic                  m_axis_tlast   // last_event
);

  localparam int unsigned CIDX_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int unsigned LANES  = ROWS + 1;

  // config registers
  logic [FADER_W-1:0] deadband_q;
  logic [NOTE_W-1:0]  base_q;
  logic [VEL_W-1:0]   velocity_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadband_q <= DEADBAND_RST;
      base_q     <= NOTE_BASE_RST;
      velocity_q <= VELOCITY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FADER_DEADBAND:  deadband_q <= cfg_data_i;
        REG_FADER_NOTE_BASE: base_q     <= cfg_data_i[NOTE_W-1:0];
        REG_KEY_VELOCITY:    velocity_q <= cfg_data_i[VEL_W-1:0];
        default: ;
      endcase
    end
  end

  // unpack scan transaction
  logic [COL_W-1:0]    col;
  logic [LEVEL_W-1:0]  levels;
  logic [SAMPLE_W-1:0] sample;
  logic [ROWS-1:0]     levels_ext;
  logic                col_ok;
  logic [CIDX_W-1:0]   cidx;

  assign col    = s_axis_tdata[COL_W-1:0];
  assign levels = s_axis_tdata[COL_W +: LEVEL_W];
  assign sample = s_axis_tdata[COL_W+LEVEL_W +: SAMPLE_W];
  assign col_ok = {1'b0, col} < (COL_W+1)'(COLUMNS);
  assign cidx   = CIDX_W'(col);

  // per-column state
  logic [ROWS-1:0]    key_levels_q   [COLUMNS];
  logic [FADER_W-1:0] fader_values_q [COLUMNS];
  logic [ROWS-1:0]    was_levels;
  logic [FADER_W-1:0] old_fader;

  assign was_levels = col_ok ? key_levels_q[cidx]   : '0;
  assign old_fader  = col_ok ? fader_values_q[cidx] : '0;

  // lanes
  logic [LANES-1:0] hit;
  event_t           ev [LANES];
  logic [FADER_W-1:0] fader_new;

  for (genvar r = 0; r < ROWS; r++) begin : g_row
    if (r < LEVEL_W) begin : g_in
      assign levels_ext[r] = levels[r];
    end else begin : g_pad
      assign levels_ext[r] = 1'b0;  // rows past the field read low
    end
    kfs_key_lane #(
      .ROW     (r),
      .COLUMNS (COLUMNS)
    ) u_lane (
      .now_i      (levels_ext[r]),
      .was_i      (was_levels[r]),
      .col_i      (col),
      .velocity_i (velocity_q),
      .hit_o      (hit[r]),
      .ev_o       (ev[r])
    );
  end

  kfs_fader_lane u_fader (
    .sample_i   (sample),
    .old_i      (old_fader),
    .deadband_i (deadband_q),
    .base_i     (base_q),
    .col_i      (col),
    .hit_o      (hit[ROWS]),
    .value_o    (fader_new),
    .ev_o       (ev[ROWS])
  );

  // accept and state update
  logic accept, can_load, load;

  assign s_axis_tready = can_load;
  assign accept        = s_axis_tvalid & can_load & col_ok;
  assign load          = accept & (|hit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < COLUMNS; c++) begin
        key_levels_q[c]   <= '0;
        fader_values_q[c] <= '0;
      end
    end else if (accept) begin
      key_levels_q[cidx] <= levels_ext;
      if (hit[ROWS]) begin
        fader_values_q[cidx] <= fader_new;
      end
    end
  end

  kfs_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .hit_i         (hit),
    .ev_i          (ev),
    .can_load_o    (can_load),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ----- hdl/kfs_checker.sv -----
// Port-level checks for the scan to MIDI event block, bound to the top level.
// Depends on kfs_pkg and key_fader_scan_to_midi_events_top.
module kfs_checker import kfs_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // stalled result stays put
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("event dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("event changed while stalled");

  // code index and status byte always agree
  a_code_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tdata[7:0] == CIN_NOTE_ON  && m_axis_tdata[15:8] == STATUS_NOTE_ON) ||
      (m_axis_tdata[7:0] == CIN_NOTE_OFF && m_axis_tdata[15:8] == STATUS_NOTE_OFF))
    else $error("code index and status disagree");

  // events of one scan leave without gaps
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("gap inside event group");

  // pad bits stay zero
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[31:30] == 2'b00)
    else $error("pad bits set");

endmodule

bind key_fader_scan_to_midi_events_top kfs_checker u_kfs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
